@@ hw/rtl/bnp_pkg.sv @@
// Shared types and constants for the box nearest point core.
`timescale 1ns / 1ps

package bnp_pkg;

   localparam int COORD_BITS = 24;
   localparam int REACH_BITS = 50;
   localparam int DIST_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIST_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;
   localparam int CMP_BITS   = (SUM_BITS > REACH_BITS) ? SUM_BITS : REACH_BITS;
   localparam int QDEPTH     = 4;
   localparam int PTR_BITS   = $clog2(QDEPTH);
   localparam int CNT_BITS   = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_BITS = 3;

   localparam logic [2:0] FACE_NONE = 3'd6;

   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_X = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_Y = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_MIN_Z = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_X = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_Y = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_MAX_Z = 3'd5;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIST_BITS-1:0]         dist_type;
   typedef logic [SQ_BITS-1:0]           sq_type;
   typedef logic [SUM_BITS-1:0]          sum_type;
   typedef logic [CMP_BITS-1:0]          cmp_type;
   typedef logic [REACH_BITS-1:0]        reach_type;
   typedef logic [CNT_BITS-1:0]          cnt_type;
   typedef logic [PTR_BITS-1:0]          ptr_type;

   typedef struct packed {
      logic      action;
      coord_type sample_x;
      coord_type sample_y;
      coord_type sample_z;
      reach_type reach_sqr;
   } req_type;

   typedef struct packed {
      logic      hit;
      logic [2:0] face_index;
      coord_type near_x;
      coord_type near_y;
      coord_type near_z;
   } rsp_type;

   typedef struct packed {
      coord_type [2:0] lo;
      coord_type [2:0] hi;
   } box_type;

   // Work item passed from the classifier to the distance unit
   typedef struct packed {
      reach_type      reach;
      logic [2:0]     face;
      coord_type [2:0] near;
      dist_type [2:0]  delta;
   } mid_type;

endpackage

@@ hw/rtl/box_nearest_point_face_core.sv @@
// A sample passes s1, s2, the work queue, b1 and the result queue. Throughput: one
// sample per cycle while req_full is low, limited by the single classifier pipeline
// and one squaring stage; a four-entry queue separates classifier and distance unit.
// Reset (synchronous, active high) empties both queues and clears the box to zero.
`timescale 1ns / 1ps

module box_nearest_point_face_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  bnp_pkg::req_type                  req_data,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output bnp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_wr_en,
   input  logic [bnp_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bnp_pkg::COORD_BITS-1:0]    csr_wdata
);
   import bnp_pkg::*;

   box_type box_ff, box_in;
   cnt_type q_count;
   mid_type q_push_data;
   mid_type q_head;
   logic    q_push;
   logic    q_pop;

   always_comb begin
      box_in = box_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MIN_X: box_in.lo[0] = csr_wdata;
            REG_MIN_Y: box_in.lo[1] = csr_wdata;
            REG_MIN_Z: box_in.lo[2] = csr_wdata;
            REG_MAX_X: box_in.hi[0] = csr_wdata;
            REG_MAX_Y: box_in.hi[1] = csr_wdata;
            REG_MAX_Z: box_in.hi[2] = csr_wdata;
            default:   box_in = box_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_ff <= '0;
      end else begin
         box_ff <= box_in;
      end
   end

   bnp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .box      (box_ff),
      .q_count  (q_count),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   bnp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head_data (q_head),
      .count     (q_count)
   );

   bnp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_count   (q_count),
      .q_data    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

@@ hw/rtl/bnp_queue.sv @@
// Short queue of classified work items between the front and back parts.
`timescale 1ns / 1ps

module bnp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bnp_pkg::mid_type  push_data,
   input  logic              pop,
   output bnp_pkg::mid_type  head_data,
   output bnp_pkg::cnt_type  count
);
   import bnp_pkg::*;

   mid_type mem_ff [QDEPTH];
   ptr_type wptr_ff, wptr_in;
   ptr_type rptr_ff, rptr_in;
   cnt_type count_ff, count_in;

   always_comb begin
      wptr_in  = push ? wptr_ff + ptr_type'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + ptr_type'(1) : rptr_ff;
      count_in = count_ff + cnt_type'(push) - cnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign head_data = mem_ff[rptr_ff];
   assign count     = count_ff;

endmodule

@@ hw/rtl/bnp_front.sv @@
// Front part: accepts samples, classifies each axis and picks the target walls.
`timescale 1ns / 1ps

module bnp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  bnp_pkg::req_type  req_data,
   input  bnp_pkg::box_type  box,
   input  bnp_pkg::cnt_type  q_count,
   output logic              q_push,
   output bnp_pkg::mid_type  q_data
);
   import bnp_pkg::*;

   typedef logic [CNT_BITS:0] credit_type;

   // stage 1: registered sample
   logic    s1_v_ff, s1_v_in;
   req_type s1_item_ff;

   // stage 2: per-axis classification
   logic             s2_v_ff, s2_v_in;
   logic [2:0]       s2_clamp_ff, s2_clamp_in;
   logic [2:0]       s2_side_ff, s2_side_in;
   coord_type [2:0]  s2_bound_ff, s2_bound_in;
   coord_type [2:0]  s2_sample_ff, s2_sample_in;
   dist_type [2:0]   s2_delta_ff, s2_delta_in;
   logic             s2_action_ff;
   reach_type        s2_reach_ff;

   credit_type used;

   // Count items in flight plus queued so the queue can never overflow
   always_comb begin
      used = credit_type'(s1_v_ff) + credit_type'(s2_v_ff) + credit_type'(q_count);
      req_full = (used >= credit_type'(QDEPTH));
      s1_v_in  = req_push && !req_full;
      s2_v_in  = s1_v_ff;
   end

   always_comb begin
      logic signed [COORD_BITS-1:0] s;
      logic signed [COORD_BITS-1:0] lo;
      logic signed [COORD_BITS-1:0] hi;
      logic signed [COORD_BITS-1:0] bnd;
      logic signed [COORD_BITS:0]   mid_sum;
      logic signed [COORD_BITS:0]   dbl;
      logic signed [COORD_BITS:0]   diff;
      logic below;
      logic above;
      s2_sample_in[0] = s1_item_ff.sample_x;
      s2_sample_in[1] = s1_item_ff.sample_y;
      s2_sample_in[2] = s1_item_ff.sample_z;
      for (int a = 0; a < 3; a++) begin
         s  = $signed(s2_sample_in[a]);
         lo = $signed(box.lo[a]);
         hi = $signed(box.hi[a]);
         below = (s < lo);
         above = !below && (s > hi);
         mid_sum = (COORD_BITS+1)'(lo) + (COORD_BITS+1)'(hi);
         dbl = {s, 1'b0};
         if (below) begin
            bnd = lo;
         end else if (above || (dbl > mid_sum)) begin
            bnd = hi;
         end else begin
            bnd = lo;
         end
         diff = (COORD_BITS+1)'(s) - (COORD_BITS+1)'(bnd);
         s2_delta_in[a] = diff[COORD_BITS] ? dist_type'(-diff) : dist_type'(diff);
         s2_clamp_in[a] = below || above;
         s2_side_in[a]  = (bnd != lo);
         s2_bound_in[a] = bnd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_v_in) begin
         s1_item_ff <= req_data;
      end
      s2_clamp_ff  <= s2_clamp_in;
      s2_side_ff   <= s2_side_in;
      s2_bound_ff  <= s2_bound_in;
      s2_sample_ff <= s2_sample_in;
      s2_delta_ff  <= s2_delta_in;
      s2_action_ff <= s1_item_ff.action;
      s2_reach_ff  <= s1_item_ff.reach_sqr;
   end

   // Stage 2: choose which axes move and which face is reported
   always_comb begin
      logic [2:0] moved;
      logic [1:0] face_axis;
      logic [1:0] pick;
      logic [1:0] rank [3];
      dist_type   d0;
      dist_type   d1;
      dist_type   d2;
      d0 = s2_delta_ff[0];
      d1 = s2_delta_ff[1];
      d2 = s2_delta_ff[2];
      if (d0 < d1) begin
         pick = (d0 < d2) ? 2'd0 : 2'd2;
      end else begin
         pick = (d1 < d2) ? 2'd1 : 2'd2;
      end
      // stable ascending order: earlier axis first on ties
      rank[0] = 2'(d1 < d0) + 2'(d2 < d0);
      rank[1] = 2'(d0 <= d1) + 2'(d2 < d1);
      rank[2] = 2'(d0 <= d2) + 2'(d1 <= d2);

      moved     = '0;
      face_axis = 2'd0;
      if (|s2_clamp_ff) begin
         moved = s2_clamp_ff;
         for (int a = 0; a < 3; a++) begin
            if (s2_clamp_ff[a]) begin
               face_axis = 2'(a);
            end
         end
      end else if (s2_action_ff) begin
         for (int a = 0; a < 3; a++) begin
            moved[a] = (rank[a] != 2'd2);
            if (rank[a] == 2'd1) begin
               face_axis = 2'(a);
            end
         end
      end else begin
         moved[pick] = 1'b1;
         face_axis   = pick;
      end

      q_data.reach = s2_reach_ff;
      q_data.face  = {face_axis, s2_side_ff[face_axis]};
      for (int a = 0; a < 3; a++) begin
         q_data.near[a]  = moved[a] ? s2_bound_ff[a] : s2_sample_ff[a];
         q_data.delta[a] = moved[a] ? s2_delta_ff[a] : '0;
      end
      q_push = s2_v_ff;
   end

endmodule

@@ hw/rtl/bnp_back.sv @@
// Back part: squared distance, reach check and result queue.
`timescale 1ns / 1ps

module bnp_back (
   input  logic              clock,
   input  logic              reset,
   input  bnp_pkg::cnt_type  q_count,
   input  bnp_pkg::mid_type  q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output bnp_pkg::rsp_type  rsp_data
);
   import bnp_pkg::*;

   typedef logic [CNT_BITS:0] credit_type;

   logic            b1_v_ff, b1_v_in;
   sq_type [2:0]    b1_sq_ff, b1_sq_in;
   reach_type       b1_reach_ff;
   logic [2:0]      b1_face_ff;
   coord_type [2:0] b1_near_ff;

   rsp_type out_mem_ff [QDEPTH];
   ptr_type owptr_ff, owptr_in;
   ptr_type orptr_ff, orptr_in;
   cnt_type ocount_ff, ocount_in;

   rsp_type    result;
   sum_type    total;
   logic       out_pop;
   credit_type used;

   // Take a work item only when the result queue has room for it
   always_comb begin
      used    = credit_type'(b1_v_ff) + credit_type'(ocount_ff);
      q_pop   = (q_count != '0) && (used < credit_type'(QDEPTH));
      b1_v_in = q_pop;
      for (int a = 0; a < 3; a++) begin
         b1_sq_in[a] = sq_type'(q_data.delta[a]) * sq_type'(q_data.delta[a]);
      end
   end

   always_comb begin
      total = sum_type'(b1_sq_ff[0]) + sum_type'(b1_sq_ff[1]) + sum_type'(b1_sq_ff[2]);
      result.hit        = (cmp_type'(total) <= cmp_type'(b1_reach_ff));
      result.face_index = result.hit ? b1_face_ff : FACE_NONE;
      result.near_x     = b1_near_ff[0];
      result.near_y     = b1_near_ff[1];
      result.near_z     = b1_near_ff[2];
   end

   always_comb begin
      out_pop   = rsp_pop && !rsp_empty;
      owptr_in  = b1_v_ff ? owptr_ff + ptr_type'(1) : owptr_ff;
      orptr_in  = out_pop ? orptr_ff + ptr_type'(1) : orptr_ff;
      ocount_in = ocount_ff + cnt_type'(b1_v_ff) - cnt_type'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff   <= 1'b0;
         owptr_ff  <= '0;
         orptr_ff  <= '0;
         ocount_ff <= '0;
      end else begin
         b1_v_ff   <= b1_v_in;
         owptr_ff  <= owptr_in;
         orptr_ff  <= orptr_in;
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         b1_sq_ff    <= b1_sq_in;
         b1_reach_ff <= q_data.reach;
         b1_face_ff  <= q_data.face;
         b1_near_ff  <= q_data.near;
      end
      if (b1_v_ff) begin
         out_mem_ff[owptr_ff] <= result;
      end
   end

   assign rsp_empty = (ocount_ff == '0);
   assign rsp_data  = out_mem_ff[orptr_ff];

endmodule
